FILE: design/video_palette_pixel_serializer_top_defines.svh
// Assertion macros used by the execution stage of the palette pixel serialiser.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef VIDEO_PALETTE_PIXEL_SERIALIZER_TOP_DEFINES_SVH
`define VIDEO_PALETTE_PIXEL_SERIALIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VPPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VPPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/vpps_pkg.sv
// Types, codes and decode helpers for the palette pixel serialiser.
// No dependencies; imported by the front, execution and top modules.
`timescale 1ns / 1ps

package vpps_pkg;

    typedef struct packed {
        logic [1:0] operation;
        logic       reg_select;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [2:0] colour;
        logic [7:0] read_data;
        logic       redraw;
        logic       bad_mode;
        logic       last;
    } result_t;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_PIXELS = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [3:0] PAL_XOR    = 4'h7;
    localparam logic [7:0] READ_VALUE = 8'hFE;

    typedef enum logic [1:0] {
        CMD_CTRL_WR,
        CMD_PAL_WR,
        CMD_READ,
        CMD_PIXELS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        BPP_1,
        BPP_2,
        BPP_4,
        BPP_8
    } bpp_t;

    // Bits per pixel from control bits [4:2].
    function automatic bpp_t bpp_decode(input logic [7:0] ctrl);
        bpp_t b;
        unique case (ctrl[3:2])
            2'd0:    b = ctrl[4] ? BPP_8 : BPP_4;
            2'd1:    b = ctrl[4] ? BPP_4 : BPP_2;
            2'd2:    b = ctrl[4] ? BPP_2 : BPP_1;
            default: b = ctrl[4] ? BPP_1 : BPP_4;
        endcase
        return b;
    endfunction

endpackage

FILE: design/vpps_fifo.sv
// Small synchronous queue of WIDTH-bit entries.
// No package dependencies; used for the command and result queues.
`timescale 1ns / 1ps

module vpps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/vpps_front.sv
// Input stage: takes transactions, classifies them into commands, drops
// undefined operations. Depends on vpps_pkg.
`timescale 1ns / 1ps

module vpps_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vpps_pkg::in_item_t item,
    output logic               cmd_wr,
    output vpps_pkg::cmd_t     cmd,
    input  logic               cmd_full
);
    import vpps_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic accept, keep;

    assign full   = valid_reg && cmd_full;
    assign cmd_wr = valid_reg && !cmd_full;
    assign accept = push && !full;
    assign cmd    = cmd_reg;

    always_comb
    begin
        cmd_next.data = item.data;
        keep          = 1'b1;
        unique case (item.operation)
            OP_WRITE:  cmd_next.kind = item.reg_select ? CMD_PAL_WR : CMD_CTRL_WR;
            OP_READ:   cmd_next.kind = CMD_READ;
            OP_PIXELS: cmd_next.kind = CMD_PIXELS;
            OP_NONE:
            begin
                cmd_next.kind = CMD_PIXELS;
                keep          = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (accept)
        begin
            valid_next = keep;
        end
        else if (cmd_wr)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: design/vpps_back.sv
// Execution stage: holds palette, control and flash state, runs commands
// in order, emitting one result per cycle while a command waits and the
// result queue has room. Uses vpps_pkg and the assertion macros header.
`timescale 1ns / 1ps

`include "video_palette_pixel_serializer_top_defines.svh"

module vpps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  vpps_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_wr,
    output vpps_pkg::result_t result
);
    import vpps_pkg::*;

    logic [3:0] pal_reg [16];
    logic [7:0] ctrl_reg;
    logic       flash_reg;
    logic [2:0] idx_reg, idx_next;

    bpp_t       bpp;
    logic [2:0] last_idx;
    logic [7:0] sh;
    logic [3:0] logical;
    logic [3:0] pal_addr;
    logic [3:0] ph;
    logic [3:0] pal_new;
    logic       go;

    assign bpp     = bpp_decode(ctrl_reg);
    assign sh      = cmd.data << idx_reg;
    assign pal_new = cmd.data[3:0] ^ PAL_XOR;
    assign go      = cmd_valid && !res_full;
    assign res_wr  = go;
    assign cmd_pop = go && result.last;

    always_comb
    begin
        unique case (bpp)
            BPP_1:
            begin
                last_idx = 3'd7;
                logical  = {4{sh[7]}};
            end
            BPP_2:
            begin
                last_idx = 3'd3;
                logical  = {sh[7], 1'b0, sh[3], 1'b0};
            end
            BPP_4:
            begin
                last_idx = 3'd1;
                logical  = {sh[7], sh[5], sh[3], sh[1]};
            end
            BPP_8:
            begin
                last_idx = 3'd0;
                logical  = {sh[7], sh[5], sh[3], sh[1]};
            end
        endcase
    end

    // single palette read port, shared by pixel lookup and write compare
    assign pal_addr = (cmd.kind == CMD_PAL_WR) ? cmd.data[7:4] : logical;
    assign ph       = pal_reg[pal_addr];

    always_comb
    begin
        result      = '0;
        result.last = 1'b1;
        unique case (cmd.kind)
            CMD_CTRL_WR: result.redraw = (flash_reg != cmd.data[0]);
            CMD_PAL_WR:  result.redraw = (ph != pal_new);
            CMD_READ:    result.read_data = READ_VALUE;
            CMD_PIXELS:
            begin
                if (bpp == BPP_8)
                begin
                    result.bad_mode = 1'b1;
                end
                else
                begin
                    result.colour = ph[2:0] ^ {3{ph[3] & flash_reg}};
                    result.last   = (idx_reg == last_idx);
                end
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (go && cmd.kind == CMD_PIXELS)
        begin
            idx_next = result.last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                pal_reg[i] <= '0;
            end
            ctrl_reg  <= '0;
            flash_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (go && cmd.kind == CMD_CTRL_WR)
            begin
                ctrl_reg  <= cmd.data;
                flash_reg <= cmd.data[0];
            end
            if (go && cmd.kind == CMD_PAL_WR)
            begin
                pal_reg[cmd.data[7:4]] <= pal_new;
            end
        end
    end

    `VPPS_ASSERT_NOW(a_idx_only_pixels, idx_reg != 3'd0, cmd_valid && cmd.kind == CMD_PIXELS, "pixel index set outside a screen byte")
    `VPPS_ASSERT_NOW(a_idx_range, cmd_valid && cmd.kind == CMD_PIXELS, idx_reg <= last_idx, "pixel index beyond last pixel")
    `VPPS_ASSERT_NOW(a_pop_on_last, cmd_pop, res_wr && result.last, "command retired without its final result")
    `VPPS_ASSERT_NXT(a_idx_hold, cmd_valid && res_full, $stable(idx_reg), "pixel index moved while stalled")

endmodule

FILE: design/video_palette_pixel_serializer_top.sv
// Top level of the palette pixel serialiser: front stage, command queue,
// execution stage and result queue. Depends on vpps_pkg and all submodules.
//
// Usage. Input transactions (operation, reg_select, data) are offered with
// push and taken at a clock edge where push is high and full is low. Results
// (colour, read_data, redraw, bad_mode, last) wait in a queue; the oldest is
// shown while empty is low and is taken when pop is high.
// A register write or read gives one result; a screen byte gives 8, 4 or 2
// pixel results, one per cycle unless the result queue is full, the final
// one with last set, or a single bad_mode result under the 8-bit setting.
// Operation 3 gives no result. Inputs pass the front stage register and
// the command queue, results the result queue. Throughput: one result per
// cycle while a command waits and the result queue has room; the
// execution stage's single palette read port sets this. Inputs are taken
// every cycle while the command queue has room.
// Reset clears palette, control, flash and all queues.
// If the receiver stops popping, the result queue fills, the execution stage
// halts mid-byte, then the command queue fills and full rises.
`timescale 1ns / 1ps

module video_palette_pixel_serializer_top #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  vpps_pkg::in_item_t item,
    output logic              empty,
    input  logic              pop,
    output vpps_pkg::result_t result
);
    import vpps_pkg::*;

    logic    fe_cmd_wr;
    cmd_t    fe_cmd;
    logic    cmd_full, cmd_empty, cmd_pop;
    logic [$bits(cmd_t)-1:0] cmd_rd_data;
    cmd_t    be_cmd;
    logic    res_full, res_wr;
    result_t be_result;
    logic [$bits(result_t)-1:0] res_rd_data;

    vpps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_wr   (fe_cmd_wr),
        .cmd      (fe_cmd),
        .cmd_full (cmd_full)
    );

    vpps_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_cmd_wr),
        .wr_data (fe_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    assign be_cmd = cmd_t'(cmd_rd_data);

    vpps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (be_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .result    (be_result)
    );

    vpps_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (be_result),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = result_t'(res_rd_data);

endmodule
